// ===== rtl/quaternion_product_and_rotate_assert.svh =====
// assertion macros shared by the quaternion unit
`ifndef QUATERNION_PRODUCT_AND_ROTATE_ASSERT_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define QPR_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("qpr assertion failed");

// next-cycle implication, off while reset is held
`define QPR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("qpr assertion failed");

`endif

// ===== rtl/qpr_pkg.sv =====
package qpr_pkg;

  // default number format, Q2.14 in 16 bits
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // item command codes
  typedef enum logic {
    CMD_PRODUCT = 1'b0,
    CMD_ROTATE  = 1'b1
  } cmd_t;

  // component order x, y, z, w
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;
  localparam logic [1:0] COMP_W = 2'd3;

  // hamilton product terms: result component k sums l[TERM_L]*r[TERM_R]
  localparam logic [1:0] TERM_L [4][4] = '{
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_W, COMP_X, COMP_Y, COMP_Z},
    '{COMP_W, COMP_X, COMP_Y, COMP_Z}
  };
  localparam logic [1:0] TERM_R [4][4] = '{
    '{COMP_X, COMP_W, COMP_Z, COMP_Y},
    '{COMP_Y, COMP_Z, COMP_W, COMP_X},
    '{COMP_Z, COMP_Y, COMP_X, COMP_W},
    '{COMP_W, COMP_X, COMP_Y, COMP_Z}
  };
  // bit t set: term t is subtracted
  localparam logic [3:0] TERM_NEG [4] = '{
    4'b1000,
    4'b0010,
    4'b0100,
    4'b1110
  };

endpackage

// ===== rtl/quaternion_product_and_rotate.sv =====
// Fixed-point quaternion unit: Hamilton product or vector rotation, pipelined.
// Input channel (in_*): in_tuser carries the command (0 = product a*b, 1 = rotate
// vector b_x,b_y,b_z by quaternion a as a*p*conj(a)), in_tdata carries a_x..a_w and
// b_x..b_w. Result channel (out_*): out_tdata carries r_x..r_w, out_tuser the
// saturation flag. All values are signed with FRAC_BITS fraction bits.
// Each item passes the stage registers s1, s2, s3 and s4 in order, for both commands;
// out_tvalid is the valid bit of the s4 stage.
// The four-stage pipeline of multiply, sum/round/saturate, multiply, sum/round/saturate
// registers takes one item per cycle while the receiver does not stall.
// A product command passes the first result through the last two stages unchanged.
// Each component is rounded to nearest (ties up) and saturated; any clip sets the flag.
// Reset clears all stage valid bits; no result is shown until a new item arrives.
// When the receiver stalls, each stage holds its item and empty stages still
// fill, so in_tready falls only once all four stages are occupied.
// in_tready depends combinationally on out_tready through the stage ready chain.
module quaternion_product_and_rotate #(
  parameter int DATA_WIDTH = qpr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic [8*DATA_WIDTH-1:0]                 in_tdata,
  // command
  input  logic                                    in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // r_x, r_y, r_z, r_w, zero fill to whole bytes
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  // saturated
  output logic                                    out_tuser
);
  import qpr_pkg::*;

  localparam int OUT_W = ((4*DATA_WIDTH+7)/8)*8;
  localparam int ACC_W = (2*DATA_WIDTH+3 > FRAC_BITS+2) ? 2*DATA_WIDTH+3 : FRAC_BITS+2;

  typedef logic signed [DATA_WIDTH-1:0]   data_t;
  typedef logic signed [2*DATA_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef struct packed {
    logic                  sat;
    logic [DATA_WIDTH-1:0] val;
  } sum_t;

  localparam acc_t MAX_V      = acc_t'((longint'(1) <<< (DATA_WIDTH-1)) - longint'(1));
  localparam acc_t MIN_V      = acc_t'(-(longint'(1) <<< (DATA_WIDTH-1)));
  localparam acc_t ROUND_HALF = acc_t'(longint'(1) <<< (FRAC_BITS-1));

  // one component of l*r or l*conj(r), rounded and saturated
  function automatic sum_t comp_sum(input prod_t p [4][4], input logic [1:0] k,
                                    input logic conj);
    acc_t acc;
    acc_t term;
    acc_t q;
    logic neg;
    sum_t res;
    acc = '0;
    for (int t = 0; t < 4; t++) begin
      term = acc_t'(p[TERM_L[k][t]][TERM_R[k][t]]);
      neg  = TERM_NEG[k][t] ^ (conj && (TERM_R[k][t] != COMP_W));
      if (neg) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = acc + ROUND_HALF;
    q   = acc >>> FRAC_BITS;
    if (q > MAX_V) begin
      res.sat = 1'b1;
      res.val = MAX_V[DATA_WIDTH-1:0];
    end else if (q < MIN_V) begin
      res.sat = 1'b1;
      res.val = MIN_V[DATA_WIDTH-1:0];
    end else begin
      res.sat = 1'b0;
      res.val = q[DATA_WIDTH-1:0];
    end
    return res;
  endfunction

  // stage registers
  logic  s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  cmd_t  s1_cmd_r, s2_cmd_r, s3_cmd_r;
  data_t s1_a_r [4];
  data_t s2_a_r [4];
  prod_t s1_p_r [4][4];
  data_t s2_t_r [4];
  logic  s2_sat_r;
  prod_t s3_p_r [4][4];
  data_t s3_t_r [4];
  logic  s3_sat_r;
  data_t s4_r_r [4];
  logic  s4_sat_r;

  logic  s1_ready, s2_ready, s3_ready, s4_ready;
  cmd_t  in_cmd;
  data_t in_a [4];
  data_t in_b [4];
  prod_t s1_p_nxt [4][4];
  data_t s2_t_nxt [4];
  logic  s2_sat_nxt;
  prod_t s3_p_nxt [4][4];
  data_t s4_r_nxt [4];
  logic  s4_sat_nxt;
  sum_t  s2_sum [4];
  sum_t  s4_sum [4];

  // stage ready chain, each stage moves when its successor has room
  assign s4_ready  = !s4_v_r || out_tready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;

  // unpack the input item, b_w is zero for a rotation
  assign in_cmd = cmd_t'(in_tuser);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_a[i] = data_t'(in_tdata[i*DATA_WIDTH +: DATA_WIDTH]);
      in_b[i] = data_t'(in_tdata[(4+i)*DATA_WIDTH +: DATA_WIDTH]);
    end
    if (in_cmd == CMD_ROTATE) begin
      in_b[COMP_W] = '0;
    end
  end

  // stage 1: all sixteen products of a and b
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1_p_nxt[i][j] = prod_t'(in_a[i]) * prod_t'(in_b[j]);
      end
    end
  end

  // stage 2: first product, rounded and saturated
  always_comb begin
    s2_sat_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      s2_sum[k]   = comp_sum(s1_p_r, 2'(k), 1'b0);
      s2_t_nxt[k] = data_t'(s2_sum[k].val);
      s2_sat_nxt  = s2_sat_nxt | s2_sum[k].sat;
    end
  end

  // stage 3: sixteen products of t and a
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s3_p_nxt[i][j] = prod_t'(s2_t_r[i]) * prod_t'(s2_a_r[j]);
      end
    end
  end

  // stage 4: t*conj(a) for a rotation, t passed through for a product
  always_comb begin
    s4_sat_nxt = s3_sat_r;
    for (int k = 0; k < 4; k++) begin
      s4_sum[k] = comp_sum(s3_p_r, 2'(k), 1'b1);
      if (s3_cmd_r == CMD_ROTATE) begin
        s4_r_nxt[k] = data_t'(s4_sum[k].val);
        s4_sat_nxt  = s4_sat_nxt | s4_sum[k].sat;
      end else begin
        s4_r_nxt[k] = s3_t_r[k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_tvalid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s3_ready) s3_v_r <= s2_v_r;
      if (s4_ready) s4_v_r <= s3_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cmd_r <= in_cmd;
      s1_a_r   <= in_a;
      s1_p_r   <= s1_p_nxt;
    end
    if (s2_ready) begin
      s2_cmd_r <= s1_cmd_r;
      s2_a_r   <= s1_a_r;
      s2_t_r   <= s2_t_nxt;
      s2_sat_r <= s2_sat_nxt;
    end
    if (s3_ready) begin
      s3_cmd_r <= s2_cmd_r;
      s3_t_r   <= s2_t_r;
      s3_sat_r <= s2_sat_r;
      s3_p_r   <= s3_p_nxt;
    end
    if (s4_ready) begin
      s4_r_r   <= s4_r_nxt;
      s4_sat_r <= s4_sat_nxt;
    end
  end

  // result item
  assign out_tvalid = s4_v_r;
  assign out_tuser  = s4_sat_r;
  assign out_tdata  = OUT_W'({s4_r_r[COMP_W], s4_r_r[COMP_Z], s4_r_r[COMP_Y], s4_r_r[COMP_X]});

  // checks
  `include "quaternion_product_and_rotate_assert.svh"

  `QPR_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, s1_v_r)
  `QPR_ASSERT_SAME(a_full_blocks, clk, rst_n, s1_v_r && s2_v_r && s3_v_r && s4_v_r && !out_tready, !in_tready)
  `QPR_ASSERT_NEXT(a_sat_kept, clk, rst_n, s3_v_r && s3_sat_r && s4_ready, out_tvalid && out_tuser)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qpr_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OW = ((4 * DW + 7) / 8) * 8;
  localparam int ONE = 1 << FB;
  localparam longint MAXV = (longint'(1) << (DW - 1)) - 1;
  localparam longint MINV = -MAXV - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  // one command item and the result it should produce
  typedef struct packed {
    cmd_t             command;
    logic [8*DW-1:0]  data;
  } quat_item_t;

  typedef struct packed {
    logic [OW-1:0] data;
    logic          sat;
  } quat_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  logic [8*DW-1:0] in_tdata = '0;
  // command
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // r_x, r_y, r_z, r_w
  logic [OW-1:0] out_tdata;
  // saturated
  logic out_tuser;

  quat_item_t   pending_items[$];
  quat_result_t awaited_results[$];
  quat_item_t   cur_item;
  int send_gap = 0;
  int recv_gap = 0;
  int errors = 0;
  int cycle_count = 0;
  int products_sent = 0;
  int rotations_sent = 0;
  int results_checked = 0;
  int clipped_seen = 0;

  quaternion_product_and_rotate #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (FB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pack components x, y, z, w into one quaternion word, x lowest
  function automatic logic [4*DW-1:0] quat(int x, int y, int z, int w);
    return {w[DW-1:0], z[DW-1:0], y[DW-1:0], x[DW-1:0]};
  endfunction

  // random quaternion of unit length in fixed point
  function automatic logic [4*DW-1:0] random_unit_quat();
    real c[4];
    real n;
    int i;
    n = 0.0;
    for (i = 0; i < 4; i++) begin
      c[i] = (real'($urandom_range(0, 65534)) - 32767.0) / 32767.0;
      n = n + c[i] * c[i];
    end
    n = $sqrt(n);
    if (n < 0.001)
      return quat(0, 0, 0, ONE);
    return quat($rtoi(c[0] / n * ONE), $rtoi(c[1] / n * ONE),
                $rtoi(c[2] / n * ONE), $rtoi(c[3] / n * ONE));
  endfunction

  function automatic void push_item(cmd_t command, logic [4*DW-1:0] a,
                                    logic [4*DW-1:0] b);
    quat_item_t it;
    it.command = command;
    it.data = {b, a};
    pending_items.push_back(it);
  endfunction

  // round half up, drop fraction bits, clip to the data range
  function automatic longint round_clip(longint s, inout bit clip);
    longint v;
    v = (s + (longint'(1) << (FB - 1))) >>> FB;
    if (v > MAXV) begin
      clip = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      clip = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  // hamilton product l*q, component order x, y, z, w
  function automatic void hamilton(input longint l[4], input longint q[4],
                                   output longint p[4], inout bit clip);
    p[0] = round_clip(l[3]*q[0] + l[0]*q[3] + l[1]*q[2] - l[2]*q[1], clip);
    p[1] = round_clip(l[3]*q[1] - l[0]*q[2] + l[1]*q[3] + l[2]*q[0], clip);
    p[2] = round_clip(l[3]*q[2] + l[0]*q[1] - l[1]*q[0] + l[2]*q[3], clip);
    p[3] = round_clip(l[3]*q[3] - l[0]*q[0] - l[1]*q[1] - l[2]*q[2], clip);
  endfunction

  function automatic quat_result_t predict_result(quat_item_t it);
    longint a[4];
    longint b[4];
    longint t[4];
    longint ca[4];
    longint r[4];
    bit clip;
    quat_result_t res;
    int i;
    clip = 1'b0;
    for (i = 0; i < 4; i++) begin
      a[i] = $signed(it.data[i*DW +: DW]);
      b[i] = $signed(it.data[(4+i)*DW +: DW]);
    end
    if (it.command == CMD_PRODUCT) begin
      hamilton(a, b, r, clip);
    end else begin
      // vector has no scalar part; conjugate negation is exact
      b[3] = 0;
      hamilton(a, b, t, clip);
      ca[0] = -a[0];
      ca[1] = -a[1];
      ca[2] = -a[2];
      ca[3] = a[3];
      hamilton(t, ca, r, clip);
    end
    res.data = '0;
    for (i = 0; i < 4; i++)
      res.data[i*DW +: DW] = r[i][DW-1:0];
    res.sat = clip;
    return res;
  endfunction

  function automatic void report_error(string msg);
    if (errors < 10)
      $display("error at cycle %0d: %s", cycle_count, msg);
    errors++;
  endfunction

  // no idling near the end, and quiet stretches along the way
  function automatic bit idling_allowed();
    return pending_items.size() > 150 && ((pending_items.size() / 128) % 3) != 0;
  endfunction

  // driver: present queued items, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(predict_result(cur_item));
        if (cur_item.command == CMD_PRODUCT)
          products_sent++;
        else
          rotations_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && idling_allowed() &&
                     $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 8);
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_item.data;
          in_tuser <= cur_item.command;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item against the oldest prediction
  always @(posedge clk) begin : watch
    quat_result_t want;
    int i;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_error($sformatf("result %h/%b with nothing expected", out_tdata, out_tuser));
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (want.sat)
            clipped_seen++;
          for (i = 0; i < 4; i++)
            if (out_tdata[i*DW +: DW] !== want.data[i*DW +: DW])
              report_error($sformatf("result %0d component %0d: expected %0d, got %0d",
                results_checked, i, $signed(want.data[i*DW +: DW]),
                $signed(out_tdata[i*DW +: DW])));
          if (out_tuser !== want.sat)
            report_error($sformatf("result %0d saturated: expected %b, got %b",
              results_checked, want.sat, out_tuser));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // cycle counter limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int k;
    int sel;
    logic [4*DW-1:0] va;
    logic [4*DW-1:0] vb;
    rst_n = 1'b0;

    // directed items
    push_item(CMD_PRODUCT, quat(0, 0, 0, 0), quat(0, 0, 0, 0));
    push_item(CMD_PRODUCT, quat(0, 0, 0, ONE), quat(1234, -5678, 9012, -3456));
    push_item(CMD_PRODUCT, quat(32767, 32767, 32767, 32767),
              quat(32767, 32767, 32767, 32767));
    push_item(CMD_PRODUCT, quat(-32768, -32768, -32768, -32768),
              quat(-32768, -32768, -32768, -32768));
    push_item(CMD_PRODUCT, quat(32767, -32768, 32767, -32768),
              quat(-32768, 32767, -32768, 32767));
    push_item(CMD_PRODUCT, quat(-32768, 0, 0, 0), quat(-32768, 0, 0, 0));
    // rounding ties, one up, one toward zero from below
    push_item(CMD_PRODUCT, quat(0, 0, 0, 1), quat(8192, 8192, 8192, 8192));
    push_item(CMD_PRODUCT, quat(0, 0, 0, 1), quat(-8192, -8192, -8192, -8192));
    push_item(CMD_PRODUCT, quat(0, 0, 0, 3), quat(8192, -8192, 24576, -24576));
    push_item(CMD_PRODUCT, quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa),
              quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    // rotations: identity, quarter turn about z, half turn about x
    push_item(CMD_ROTATE, quat(0, 0, 0, ONE), quat(32767, -32768, 123, 0));
    push_item(CMD_ROTATE, quat(0, 0, 11585, 11585), quat(ONE, 0, 0, 0));
    push_item(CMD_ROTATE, quat(ONE, 0, 0, 0), quat(1000, 2000, -3000, 0));
    // scalar of b must be ignored
    push_item(CMD_ROTATE, quat(0, 0, 11585, 11585), quat(ONE, 0, 0, 32767));
    push_item(CMD_ROTATE, quat(0, 0, 11585, 11585), quat(ONE, 0, 0, -32768));
    // clipping in the first stage, and conjugate of the most negative value
    push_item(CMD_ROTATE, quat(-32768, -32768, -32768, -32768),
              quat(32767, 32767, 32767, 32767));
    push_item(CMD_ROTATE, quat(32767, 32767, 32767, 32767),
              quat(-32768, -32768, -32768, 0));
    push_item(CMD_ROTATE, quat(0, 0, 0, -32768), quat(32767, -32768, 32767, 0));
    push_item(CMD_ROTATE, quat(-32768, 0, 0, 0), quat(0, -32768, 0, 0));
    push_item(CMD_ROTATE, quat(9459, 9459, 9459, 9459), quat(0, 0, 0, 0));

    // random items: mostly unit rotations and products, the rest raw bits
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        va = {$urandom, $urandom};
        vb = {$urandom, $urandom};
        push_item(cmd_t'($urandom_range(0, 1)), va, vb);
      end else if (sel < 17) begin
        if ($urandom_range(0, 1) == 0)
          vb = {$urandom, $urandom};
        else
          vb = quat($urandom_range(0, 32766) - 16383, $urandom_range(0, 32766) - 16383,
                    $urandom_range(0, 32766) - 16383, $urandom_range(0, 32766) - 16383);
        push_item(CMD_ROTATE, random_unit_quat(), vb);
      end else begin
        push_item(CMD_PRODUCT, random_unit_quat(), random_unit_quat());
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all items to go in and all results to come out
    while (pending_items.size() > 0 || in_tvalid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d product and %0d rotate items",
             results_checked, products_sent, rotations_sent);
    $display("%0d results were clipped, %0d errors", clipped_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
